/* src/assert_macros.svh */
// Assertion helper macros shared by the blur RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abb assertion failed");

// Next-cycle implication, disabled during reset.
`define ABB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abb assertion failed");

`endif

/* src/abb_pkg.sv */
// Shared types and constants for the ARGB box blur.
// No dependencies.
package abb_pkg;

    localparam int CH_COUNT     = 4;
    localparam int CH_BITS      = 8;
    localparam int PIXEL_W      = 32;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RWAIT,
        ST_COLUMN,
        ST_EMIT,
        ST_DIV,
        ST_OUT
    } back_state_t;

    // Width of a packed command between front and back.
    function automatic int cmd_width(int cw, int sw, int nw);
        return PIXEL_W + cw + 2 + sw + 2 * nw + 2 + sw;
    endfunction

endpackage

/* src/argb_box_blur_edge_clipped.sv */
// ARGB box blur, edge clipped: one column command per accepted item, queued
// from the front to the back. Depends on abb_pkg, abb_front, abb_cmd_fifo, abb_back.
// An item reads its N stored rows (N up to 2*RADIUS) through the single read port
// of the line store, then each of its results goes through the 8-step divider.
// The back takes one item at a time, while the command queue lets the front
// accept more; a row end gives its results in turn. Ignored items give no command.
// Reset: position zero, width 640, height 480; line store is not cleared.
module argb_box_blur_edge_clipped #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int RADIUS     = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [abb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [abb_pkg::PIXEL_W-1:0]     pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [abb_pkg::PIXEL_W-1:0]     pixel_out,
    output logic                            frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(2 * RADIUS);
    localparam int NW    = $clog2(2 * RADIUS + 2);
    localparam int CMD_W = abb_pkg::cmd_width(CW, SW, NW);

    logic             push_valid, push_ready, pop_valid, pop_ready;
    logic [CMD_W-1:0] push_data, pop_data;

    abb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RADIUS     (RADIUS),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .pixel_in  (pixel_in),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd_data  (push_data)
    );

    abb_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    abb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule

/* src/abb_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module abb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/abb_cmd_fifo.sv */
// Short command queue between front and back of the blur.
// No dependencies.
module abb_cmd_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/abb_front.sv */
// Front of the blur: raster position tracking, frame size registers and
// item classification into column commands. Depends on abb_pkg.
module abb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int RADIUS     = 2,
    parameter int CMD_W      = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [abb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [abb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [abb_pkg::PIXEL_W-1:0]        pixel_in,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output logic [CMD_W-1:0]                   cmd_data
);

    localparam int SPAN       = 2 * RADIUS + 1;
    localparam int STORE_ROWS = 2 * RADIUS;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int XW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int YW         = $clog2(MAX_HEIGHT + RADIUS);
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int NW         = $clog2(SPAN + 1);
    localparam int RST_W = (abb_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : abb_pkg::RESET_WIDTH;
    localparam int RST_H = (abb_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : abb_pkg::RESET_HEIGHT;

    typedef struct packed {
        logic [abb_pkg::PIXEL_W-1:0] pix;
        logic [CW-1:0]               ix;
        logic                        is_real;
        logic                        store_only;
        logic [SW-1:0]               rd_slot;
        logic [NW-1:0]               nreads;
        logic [NW-1:0]               mh;
        logic                        last_col;
        logic                        oy_last;
        logic [SW-1:0]               wr_slot;
    } cmd_t;

    logic [XW-1:0] uw_reg, uw_next;
    logic [HW-1:0] uh_reg, uh_next;
    logic [CW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;

    cmd_t        cmd;
    logic        do_proc;
    logic        accept;
    logic [31:0] row32, col32, w32, h32, r0, cfg32;
    logic [SW-1:0] slot_inc;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid && do_proc;
    assign cmd_data  = CMD_W'(cmd);
    assign accept    = in_valid && in_ready && do_proc;

    always_comb
    begin
        uw_next   = uw_reg;
        uh_next   = uh_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        row32 = 32'(row_reg);
        col32 = 32'(col_reg);
        w32   = 32'(uw_reg);
        h32   = 32'(uh_reg);
        cfg32 = 32'(cfg_data);
        slot_inc = (slot_reg == SW'(STORE_ROWS - 1)) ? '0 : slot_reg + 1'b1;

        if (kind == abb_pkg::KIND_PIXEL)
        begin
            do_proc = row32 < h32;
        end
        else
        begin
            do_proc = row32 >= h32;
        end

        r0 = (row32 >= 32'(STORE_ROWS)) ? row32 - 32'(STORE_ROWS) : 32'd0;

        cmd.pix        = pixel_in;
        cmd.ix         = col_reg;
        cmd.is_real    = kind == abb_pkg::KIND_PIXEL;
        cmd.store_only = row32 < 32'(RADIUS);
        cmd.rd_slot    = (row32 >= 32'(STORE_ROWS)) ? slot_reg : '0;
        cmd.wr_slot    = slot_reg;
        cmd.last_col   = col32 == w32 - 32'd1;
        cmd.oy_last    = row32 == h32 - 32'd1 + 32'(RADIUS);
        if (cmd.store_only)
        begin
            cmd.nreads = '0;
            cmd.mh     = '0;
        end
        else if (cmd.is_real)
        begin
            cmd.nreads = NW'(row32 - r0);
            cmd.mh     = NW'(row32 - r0 + 32'd1);
        end
        else
        begin
            cmd.nreads = NW'(h32 - r0);
            cmd.mh     = NW'(h32 - r0);
        end

        if (accept)
        begin
            if (!cmd.is_real && row32 >= h32 - 32'd1 + 32'(RADIUS) && cmd.last_col)
            begin
                // last drain column of the frame: start over
                col_next  = '0;
                row_next  = '0;
                slot_next = '0;
            end
            else if (cmd.last_col)
            begin
                col_next  = '0;
                row_next  = row_reg + 1'b1;
                slot_next = slot_inc;
                // short frame skips the store-only drain rows, straight to row RADIUS
                if (cmd.is_real && row32 + 32'd1 == h32 && row32 + 32'd1 < 32'(RADIUS))
                begin
                    row_next  = YW'(RADIUS);
                    slot_next = SW'(RADIUS);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (cfg_wen)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
            if (cfg_index == abb_pkg::REG_IMAGE_WIDTH)
            begin
                cfg32 = 32'(cfg_data[abb_pkg::WIDTH_REG_W-1:0]);
                if (cfg32 == 32'd0)
                begin
                    uw_next = XW'(1);
                end
                else if (cfg32 > 32'(MAX_WIDTH))
                begin
                    uw_next = XW'(MAX_WIDTH);
                end
                else
                begin
                    uw_next = XW'(cfg32);
                end
            end
            else
            begin
                cfg32 = 32'(cfg_data[abb_pkg::HEIGHT_REG_W-1:0]);
                if (cfg32 == 32'd0)
                begin
                    uh_next = HW'(1);
                end
                else if (cfg32 > 32'(MAX_HEIGHT))
                begin
                    uh_next = HW'(MAX_HEIGHT);
                end
                else
                begin
                    uh_next = HW'(cfg32);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uw_reg   <= XW'(RST_W);
            uh_reg   <= HW'(RST_H);
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            uw_reg   <= uw_next;
            uh_reg   <= uh_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

endmodule

/* src/abb_back.sv */
// Back of the blur: column sums from the line store, column window,
// clipped window sums and an iterative divider per channel.
// Depends on abb_pkg, abb_ram and assert_macros.svh.
`include "assert_macros.svh"

module abb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2,
    parameter int CMD_W     = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [CMD_W-1:0]            cmd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [abb_pkg::PIXEL_W-1:0] pixel_out,
    output logic                        frame_last
);

    localparam int SPAN       = 2 * RADIUS + 1;
    localparam int STORE_ROWS = 2 * RADIUS;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int NW         = $clog2(SPAN + 1);
    localparam int COL_W      = $clog2(SPAN * 255 + 1);
    localparam int AREA_W     = $clog2(SPAN * SPAN + 1);
    localparam int DW         = AREA_W + abb_pkg::CH_BITS;
    localparam int STEP_W     = $clog2(abb_pkg::CH_BITS);
    localparam int AW         = SW + CW;
    localparam int DEPTH      = STORE_ROWS << CW;

    typedef struct packed {
        logic [abb_pkg::PIXEL_W-1:0] pix;
        logic [CW-1:0]               ix;
        logic                        is_real;
        logic                        store_only;
        logic [SW-1:0]               rd_slot;
        logic [NW-1:0]               nreads;
        logic [NW-1:0]               mh;
        logic                        last_col;
        logic                        oy_last;
        logic [SW-1:0]               wr_slot;
    } cmd_t;

    abb_pkg::back_state_t state_reg, state_next;

    cmd_t              cmd_reg, cmd_next, cmd_in;
    logic [SW-1:0]     rd_slot_reg, rd_slot_next;
    logic [NW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [COL_W-1:0]  colsum_reg [abb_pkg::CH_COUNT];
    logic [COL_W-1:0]  colsum_next [abb_pkg::CH_COUNT];
    logic [COL_W-1:0]  win_reg [SPAN][abb_pkg::CH_COUNT];
    logic [COL_W-1:0]  win_next [SPAN][abb_pkg::CH_COUNT];
    logic [CW-1:0]     ox_reg, ox_next;
    logic [DW-1:0]     rem_reg [abb_pkg::CH_COUNT];
    logic [DW-1:0]     rem_next [abb_pkg::CH_COUNT];
    logic [DW-1:0]     dsh_reg, dsh_next;
    logic [abb_pkg::CH_BITS-1:0] q_reg [abb_pkg::CH_COUNT];
    logic [abb_pkg::CH_BITS-1:0] q_next [abb_pkg::CH_COUNT];
    logic [STEP_W-1:0] step_reg, step_next;
    logic              fl_reg, fl_next;
    logic              out_valid_reg, out_valid_next;
    logic [abb_pkg::PIXEL_W-1:0] pixel_out_reg, pixel_out_next;
    logic              frame_last_reg, frame_last_next;

    logic              ram_wr_en, ram_rd_en;
    logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [abb_pkg::PIXEL_W-1:0] ram_rd_data;

    logic [31:0]       ox32, ix32, c0, c1, klo, khi;
    logic [NW-1:0]     cols;
    logic [2*NW-1:0]   prod;
    logic [DW-1:0]     acc [abb_pkg::CH_COUNT];
    logic              ge;

    assign cmd_in     = cmd_t'(cmd_data);
    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

    assign ram_wr_addr = {cmd_reg.wr_slot, cmd_reg.ix};
    assign ram_rd_addr = {rd_slot_reg, cmd_reg.ix};

    abb_ram #(
        .WIDTH (abb_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd_reg.pix),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Clipped window sum and area for the output at ox_reg.
    always_comb
    begin
        ox32 = 32'(ox_reg);
        ix32 = 32'(cmd_reg.ix);
        c0   = (ox32 >= 32'(RADIUS)) ? ox32 - 32'(RADIUS) : 32'd0;
        c1   = (ox32 + 32'(RADIUS) > ix32) ? ix32 : ox32 + 32'(RADIUS);
        klo  = ix32 - c1;
        khi  = ix32 - c0;
        cols = NW'(c1 - c0 + 32'd1);
        prod = {{NW{1'b0}}, cols} * {{NW{1'b0}}, cmd_reg.mh};
        for (int ch = 0; ch < abb_pkg::CH_COUNT; ch++)
        begin
            acc[ch] = '0;
            for (int k = 0; k < SPAN; k++)
            begin
                if (32'(k) >= klo && 32'(k) <= khi)
                begin
                    acc[ch] = acc[ch] + DW'(win_reg[k][ch]);
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        rd_slot_next    = rd_slot_reg;
        rd_cnt_next     = rd_cnt_reg;
        colsum_next     = colsum_reg;
        win_next        = win_reg;
        ox_next         = ox_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        step_next       = step_reg;
        fl_next         = fl_reg;
        out_valid_next  = out_valid_reg;
        pixel_out_next  = pixel_out_reg;
        frame_last_next = frame_last_reg;
        cmd_ready       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ge              = 1'b0;

        unique case (state_reg)
            abb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next     = cmd_in;
                    rd_slot_next = cmd_in.rd_slot;
                    rd_cnt_next  = cmd_in.nreads;
                    for (int ch = 0; ch < abb_pkg::CH_COUNT; ch++)
                    begin
                        colsum_next[ch] = cmd_in.is_real
                            ? COL_W'(cmd_in.pix[abb_pkg::PIXEL_W-1-abb_pkg::CH_BITS*ch -:
                                                abb_pkg::CH_BITS])
                            : '0;
                    end
                    state_next = abb_pkg::ST_READ;
                end
            end
            abb_pkg::ST_READ:
            begin
                if (rd_cnt_reg == '0)
                begin
                    state_next = abb_pkg::ST_COLUMN;
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    state_next = abb_pkg::ST_RWAIT;
                end
            end
            abb_pkg::ST_RWAIT:
            begin
                for (int ch = 0; ch < abb_pkg::CH_COUNT; ch++)
                begin
                    colsum_next[ch] = colsum_reg[ch] + COL_W'(
                        ram_rd_data[abb_pkg::PIXEL_W-1-abb_pkg::CH_BITS*ch -:
                                    abb_pkg::CH_BITS]);
                end
                rd_slot_next = (rd_slot_reg == SW'(STORE_ROWS - 1)) ? '0
                                                                    : rd_slot_reg + 1'b1;
                rd_cnt_next  = rd_cnt_reg - 1'b1;
                state_next   = abb_pkg::ST_READ;
            end
            abb_pkg::ST_COLUMN:
            begin
                // store write comes after this column's reads of the same slot
                ram_wr_en = cmd_reg.is_real;
                if (cmd_reg.store_only)
                begin
                    state_next = abb_pkg::ST_IDLE;
                end
                else
                begin
                    for (int k = SPAN - 1; k > 0; k--)
                    begin
                        win_next[k] = win_reg[k-1];
                    end
                    win_next[0] = colsum_reg;
                    if (cmd_reg.last_col)
                    begin
                        ox_next = (32'(cmd_reg.ix) >= 32'(RADIUS))
                                  ? cmd_reg.ix - CW'(RADIUS) : '0;
                        state_next = abb_pkg::ST_EMIT;
                    end
                    else if (32'(cmd_reg.ix) >= 32'(RADIUS))
                    begin
                        ox_next    = cmd_reg.ix - CW'(RADIUS);
                        state_next = abb_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = abb_pkg::ST_IDLE;
                    end
                end
            end
            abb_pkg::ST_EMIT:
            begin
                rem_next   = acc;
                dsh_next   = DW'(AREA_W'(prod)) << (abb_pkg::CH_BITS - 1);
                step_next  = '0;
                fl_next    = cmd_reg.oy_last && cmd_reg.last_col && ox_reg == cmd_reg.ix;
                state_next = abb_pkg::ST_DIV;
            end
            abb_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per channel a cycle
                for (int ch = 0; ch < abb_pkg::CH_COUNT; ch++)
                begin
                    ge = rem_reg[ch] >= dsh_reg;
                    rem_next[ch] = ge ? rem_reg[ch] - dsh_reg : rem_reg[ch];
                    q_next[ch]   = {q_reg[ch][abb_pkg::CH_BITS-2:0], ge};
                    pixel_out_next[abb_pkg::PIXEL_W-1-abb_pkg::CH_BITS*ch -:
                                   abb_pkg::CH_BITS] = q_next[ch];
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(abb_pkg::CH_BITS - 1))
                begin
                    out_valid_next  = 1'b1;
                    frame_last_next = fl_reg;
                    state_next      = abb_pkg::ST_OUT;
                end
            end
            abb_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (cmd_reg.last_col && ox_reg != cmd_reg.ix)
                    begin
                        ox_next    = ox_reg + 1'b1;
                        state_next = abb_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = abb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = abb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rd_slot_reg    <= rd_slot_next;
        rd_cnt_reg     <= rd_cnt_next;
        colsum_reg     <= colsum_next;
        win_reg        <= win_next;
        ox_reg         <= ox_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        step_reg       <= step_next;
        fl_reg         <= fl_next;
        pixel_out_reg  <= pixel_out_next;
        frame_last_reg <= frame_last_next;
    end

    `ABB_ASSERT_IMP(a_out_only_in_out_state, out_valid_reg, state_reg == abb_pkg::ST_OUT)
    `ABB_ASSERT_NXT(a_div_done_gives_item,
        state_reg == abb_pkg::ST_DIV && step_reg == STEP_W'(abb_pkg::CH_BITS - 1),
        out_valid_reg)
    `ABB_ASSERT_IMP(a_rwait_follows_read, state_reg == abb_pkg::ST_RWAIT,
        $past(ram_rd_en))
    `ABB_ASSERT_IMP(a_read_count_bound, state_reg == abb_pkg::ST_READ,
        rd_cnt_reg <= NW'(STORE_ROWS))

endmodule
